// ===== sv/sdr_pkg.sv =====
// Shared types, constants and rounding helpers for the 6D-to-rotation-matrix pipeline.
// No dependencies.
package sdr_pkg;

  localparam int SDR_DW       = 16;  // field width
  localparam int SDR_RESW     = 27;  // residual vector width, Q.20
  localparam int SDR_NORM_TOP = 24;  // normalize until max magnitude reaches 2^24
  localparam int SDR_QW       = 15;  // unsigned quotient bits, holds 0..16384
  localparam int SDR_SHN      = 6;   // shift steps: 16, 8, 4, 2, 1, 1
  localparam logic [SDR_QW-1:0] SDR_QONE = SDR_QW'(16384);

  typedef logic signed [SDR_DW-1:0] sdr_data_t;

  // x / 2^20, half away from zero
  function automatic logic signed [30:0] sdr_rnd20(input logic signed [49:0] x);
    logic [49:0] mg;
    logic [29:0] q;
    begin
      mg = x[49] ? (~x + 50'd1) : x;
      q  = 30'((mg + 50'(1 << 19)) >> 20);
      sdr_rnd20 = x[49] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  endfunction

  // x / 2^14, half away from zero, clamped to +-16384
  function automatic sdr_data_t sdr_rnd14_clamp(input logic signed [31:0] x);
    logic [31:0] mg;
    logic [17:0] q;
    logic [SDR_DW-1:0] c;
    begin
      mg = x[31] ? (~x + 32'd1) : x;
      q  = 18'((mg + 32'(1 << 13)) >> 14);
      c  = (q > 18'(SDR_QONE)) ? SDR_DW'(SDR_QONE) : SDR_DW'(q);
      sdr_rnd14_clamp = x[31] ? -$signed(c) : $signed(c);
    end
  endfunction

endpackage

// ===== sv/sdr_if.sv =====
// Valid/ready channel interfaces for input vectors and result matrices.
// Depends on sdr_pkg.
interface sdr_in_if import sdr_pkg::*; ();
  logic      valid;
  logic      ready;
  sdr_data_t a_x, b_x, a_y, b_y, a_z, b_z;
  modport source (output valid, a_x, b_x, a_y, b_y, a_z, b_z, input ready);
  modport sink   (input valid, a_x, b_x, a_y, b_y, a_z, b_z, output ready);
endinterface

interface sdr_out_if import sdr_pkg::*; ();
  logic      valid;
  logic      ready;
  sdr_data_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic      degenerate;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
                  output ready);
endinterface

// ===== sv/six_d_to_rotation_matrix_unit.sv =====
// Top level: Gram-Schmidt rotation matrix from two 3-vectors (6D representation).
// Depends on sdr_pkg, sdr_if (sdr_in_if, sdr_out_if) and sdr_norm.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        a_x b_x a_y b_y a_z b_z  (Q4.12)
//   out_ch    out   valid/ready        m00..m22 (Q1.14), degenerate
//
// One item per cycle while out_ch is not stalled. The square root is 26 bits wide in
// the normalizer for a and 28 bits wide in the normalizer for the residual.
// The square-root and divide stages of the two normalizers set the depth.
// Reset clears only valid bits. When out_ch holds an item not taken, the whole
// pipeline freezes; in_ch.ready is low for exactly those cycles.
module six_d_to_rotation_matrix_unit import sdr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  sdr_in_if.sink    in_ch,
  sdr_out_if.source out_ch
);

  logic en;
  logic ov_r;

  assign en          = !ov_r || out_ch.ready;
  assign in_ch.ready = en;

  // first normalizer: b1 = a/|a|, b carried alongside
  logic            n1_v, n1_zero;
  sdr_data_t       b1 [3];
  logic [47:0]     n1_side;

  sdr_norm #(.VW(SDR_DW), .SW(48)) u_norm_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ch.valid),
    .v_x(in_ch.a_x), .v_y(in_ch.a_y), .v_z(in_ch.a_z),
    .in_side({in_ch.b_x, in_ch.b_y, in_ch.b_z}),
    .out_valid(n1_v), .o_x(b1[0]), .o_y(b1[1]), .o_z(b1[2]),
    .out_zero(n1_zero), .out_side(n1_side)
  );

  typedef struct packed {
    logic [2:0][SDR_DW-1:0] b1;
    logic [2:0][SDR_DW-1:0] b;
    logic                   deg;
  } car_t;

  car_t c1_r, c2_r, c3_r, c4_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [31:0] p1_r [3];
  logic signed [33:0] d_r;
  logic signed [49:0] e_r [3];
  logic signed [SDR_RESW-1:0] r_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= n1_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  logic signed [31:0] r_wide [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      r_wide[i] = ($signed(32'(signed'(c3_r.b[i]))) <<< 8) - 32'(sdr_rnd20(e_r[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r.b1  <= {b1[2], b1[1], b1[0]};
      c1_r.b   <= {n1_side[15:0], n1_side[31:16], n1_side[47:32]};
      c1_r.deg <= n1_zero;
      p1_r[0]  <= b1[0] * $signed(n1_side[47:32]);
      p1_r[1]  <= b1[1] * $signed(n1_side[31:16]);
      p1_r[2]  <= b1[2] * $signed(n1_side[15:0]);
      c2_r     <= c1_r;
      d_r      <= 34'(p1_r[0]) + 34'(p1_r[1]) + 34'(p1_r[2]);
      c3_r     <= c2_r;
      for (int i = 0; i < 3; i++) e_r[i] <= d_r * $signed(c2_r.b1[i]);
      c4_r     <= c3_r;
      for (int i = 0; i < 3; i++) r_r[i] <= SDR_RESW'(r_wide[i]);
    end
  end

  // second normalizer: b2 = normalize(residual)
  logic        n2_v, n2_zero;
  sdr_data_t   b2 [3];
  logic [48:0] n2_side;

  sdr_norm #(.VW(SDR_RESW), .SW(49)) u_norm_r (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r),
    .v_x(r_r[0]), .v_y(r_r[1]), .v_z(r_r[2]),
    .in_side({c4_r.b1, c4_r.deg}),
    .out_valid(n2_v), .o_x(b2[0]), .o_y(b2[1]), .o_z(b2[2]),
    .out_zero(n2_zero), .out_side(n2_side)
  );

  sdr_data_t a1 [3];
  assign a1[0] = $signed(n2_side[16:1]);
  assign a1[1] = $signed(n2_side[32:17]);
  assign a1[2] = $signed(n2_side[48:33]);

  // cross product
  logic               v5_r, deg5_r;
  sdr_data_t          b1_5_r [3], b2_5_r [3];
  logic signed [31:0] xp_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= n2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      deg5_r  <= n2_side[0] | n2_zero;
      b1_5_r  <= a1;
      b2_5_r  <= b2;
      xp_r[0] <= a1[1] * b2[2];
      xp_r[1] <= a1[2] * b2[1];
      xp_r[2] <= a1[2] * b2[0];
      xp_r[3] <= a1[0] * b2[2];
      xp_r[4] <= a1[0] * b2[1];
      xp_r[5] <= a1[1] * b2[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.m00        <= b1_5_r[0];
      out_ch.m10        <= b1_5_r[1];
      out_ch.m20        <= b1_5_r[2];
      out_ch.m01        <= b2_5_r[0];
      out_ch.m11        <= b2_5_r[1];
      out_ch.m21        <= b2_5_r[2];
      out_ch.m02        <= sdr_rnd14_clamp(xp_r[0] - xp_r[1]);
      out_ch.m12        <= sdr_rnd14_clamp(xp_r[2] - xp_r[3]);
      out_ch.m22        <= sdr_rnd14_clamp(xp_r[4] - xp_r[5]);
      out_ch.degenerate <= deg5_r;
    end
  end
  assign out_ch.valid = ov_r;

`ifndef SYNTHESIS
  a_deg_col2_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.degenerate) |->
      (out_ch.m02 == 16'sd0 && out_ch.m12 == 16'sd0 && out_ch.m22 == 16'sd0))
    else $error("degenerate item with nonzero third column");

  a_nondeg_col0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.degenerate) |->
      (out_ch.m00 != 16'sd0 || out_ch.m10 != 16'sd0 || out_ch.m20 != 16'sd0))
    else $error("nondegenerate item with zero first column");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      (out_ch.m00 <= 16'sd16384 && out_ch.m00 >= -16'sd16384 &&
       out_ch.m11 <= 16'sd16384 && out_ch.m11 >= -16'sd16384 &&
       out_ch.m22 <= 16'sd16384 && out_ch.m22 >= -16'sd16384))
    else $error("matrix entry out of Q1.14 range");
`endif

endmodule

// ===== sv/sdr_norm.sv =====
// Pipelined 3-vector normalizer to Q1.14: shift stages, squares, one-bit-per-stage
// square root and restoring divide. Depends on sdr_pkg.
module sdr_norm import sdr_pkg::*; #(
  parameter int VW = 16,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] v_x,
  input  logic signed [VW-1:0] v_y,
  input  logic signed [VW-1:0] v_z,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output sdr_data_t            o_x,
  output sdr_data_t            o_y,
  output sdr_data_t            o_z,
  output logic                 out_zero,
  output logic [SW-1:0]        out_side
);

  localparam int UW  = (VW > SDR_NORM_TOP + 1) ? VW : SDR_NORM_TOP + 1;
  localparam int SQW = 2 * UW + 2;
  localparam int RW  = UW + 1;
  localparam int NW  = UW + SDR_QW + 1;
  localparam logic [UW-1:0] THR = UW'(1) << SDR_NORM_TOP;

  typedef struct packed {
    logic [2:0][UW-1:0] u;
    logic [UW-1:0]      m;
    logic [2:0]         sgn;
    logic               zero;
    logic [SW-1:0]      side;
  } fr_t;

  typedef struct packed {
    logic [2:0][UW-1:0] u;
    logic [SQW-1:0]     rem;
    logic [RW-1:0]      root;
    logic [2:0]         sgn;
    logic               zero;
    logic [SW-1:0]      side;
  } sq_t;

  typedef struct packed {
    logic [2:0][NW-1:0]     rem;
    logic [RW:0]            dd;
    logic [2:0][SDR_QW-1:0] q;
    logic [2:0]             sgn;
    logic                   zero;
    logic [SW-1:0]          side;
  } dv_t;

  function automatic fr_t sh_step(input fr_t f, input int s);
    begin
      sh_step = f;
      if (f.m < (THR >> (s - 1))) begin
        sh_step.m = f.m << s;
        for (int i = 0; i < 3; i++) sh_step.u[i] = f.u[i] << s;
      end
    end
  endfunction

  function automatic sq_t sq_step(input sq_t s, input int b);
    logic [SQW:0] trial;
    begin
      trial   = ((SQW+1)'(s.root) << (b + 1)) + ((SQW+1)'(1) << (2 * b));
      sq_step = s;
      if ({1'b0, s.rem} >= trial) begin
        sq_step.rem     = s.rem - trial[SQW-1:0];
        sq_step.root[b] = 1'b1;
      end
    end
  endfunction

  function automatic dv_t dv_step(input dv_t d, input int b);
    logic [NW-1:0] trial;
    begin
      trial   = NW'(d.dd) << b;
      dv_step = d;
      for (int i = 0; i < 3; i++) begin
        if (d.rem[i] >= trial) begin
          dv_step.rem[i]  = d.rem[i] - trial;
          dv_step.q[i][b] = 1'b1;
        end
      end
    end
  endfunction

  // magnitudes and max
  logic [VW-1:0] mg [3];
  logic [VW-1:0] mx;
  fr_t           fr0;

  always_comb begin
    mg[0] = v_x[VW-1] ? (~v_x + VW'(1)) : v_x;
    mg[1] = v_y[VW-1] ? (~v_y + VW'(1)) : v_y;
    mg[2] = v_z[VW-1] ? (~v_z + VW'(1)) : v_z;
    mx    = (mg[0] > mg[1]) ? mg[0] : mg[1];
    mx    = (mg[2] > mx) ? mg[2] : mx;
    fr0.u[0] = UW'(mg[0]);
    fr0.u[1] = UW'(mg[1]);
    fr0.u[2] = UW'(mg[2]);
    fr0.m    = UW'(mx);
    fr0.sgn  = {v_z[VW-1], v_y[VW-1], v_x[VW-1]};
    fr0.zero = (mx == '0);
    fr0.side = in_side;
  end

  fr_t  fr_r [SDR_SHN+1];
  logic fv_r [SDR_SHN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) fv_r[0] <= 1'b0;
    else if (en) fv_r[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) fr_r[0] <= fr0;
  end

  for (genvar i = 1; i <= SDR_SHN; i++) begin : g_sh
    localparam int S = (i < SDR_SHN) ? (16 >> (i - 1)) : 1;
    always_ff @(posedge clk) begin
      if (!rst_n) fv_r[i] <= 1'b0;
      else if (en) fv_r[i] <= fv_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) fr_r[i] <= sh_step(fr_r[i-1], S);
    end
  end

  // squares
  fr_t                  pf_r;
  logic [2:0][2*UW-1:0] p_r;
  logic                 pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else if (en) pv_r <= fv_r[SDR_SHN];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pf_r <= fr_r[SDR_SHN];
      for (int i = 0; i < 3; i++) p_r[i] <= fr_r[SDR_SHN].u[i] * fr_r[SDR_SHN].u[i];
    end
  end

  // square root, one result bit per stage
  sq_t  sq_r [RW+1];
  logic sv_r [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else if (en) sv_r[0] <= pv_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].u    <= pf_r.u;
      sq_r[0].rem  <= SQW'(p_r[0]) + SQW'(p_r[1]) + SQW'(p_r[2]);
      sq_r[0].root <= '0;
      sq_r[0].sgn  <= pf_r.sgn;
      sq_r[0].zero <= pf_r.zero;
      sq_r[0].side <= pf_r.side;
    end
  end

  for (genvar j = 1; j <= RW; j++) begin : g_sq
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[j] <= 1'b0;
      else if (en) sv_r[j] <= sv_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) sq_r[j] <= sq_step(sq_r[j-1], RW - j);
    end
  end

  // restoring divide, one quotient bit per stage
  dv_t  dv_r [SDR_QW+1];
  logic dvv_r [SDR_QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dvv_r[0] <= 1'b0;
    else if (en) dvv_r[0] <= sv_r[RW];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        dv_r[0].rem[i] <= (NW'(sq_r[RW].u[i]) << SDR_QW) + NW'(sq_r[RW].root);
      dv_r[0].dd   <= {sq_r[RW].root, 1'b0};
      dv_r[0].q    <= '0;
      dv_r[0].sgn  <= sq_r[RW].sgn;
      dv_r[0].zero <= sq_r[RW].zero;
      dv_r[0].side <= sq_r[RW].side;
    end
  end

  for (genvar j = 1; j <= SDR_QW; j++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) dvv_r[j] <= 1'b0;
      else if (en) dvv_r[j] <= dvv_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) dv_r[j] <= dv_step(dv_r[j-1], SDR_QW - j);
    end
  end

  // clamp, sign, zero override
  dv_t       dl;
  sdr_data_t o_nxt [3];

  always_comb begin
    dl = dv_r[SDR_QW];
    for (int i = 0; i < 3; i++) begin
      o_nxt[i] = (dl.q[i] > SDR_QONE) ? SDR_DW'(SDR_QONE) : SDR_DW'(dl.q[i]);
      if (dl.sgn[i]) o_nxt[i] = -o_nxt[i];
      if (dl.zero) o_nxt[i] = '0;
    end
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dvv_r[SDR_QW];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_x      <= o_nxt[0];
      o_y      <= o_nxt[1];
      o_z      <= o_nxt[2];
      out_zero <= dl.zero;
      out_side <= dl.side;
    end
  end
  assign out_valid = out_valid_r;

endmodule
